>>> hdl/assert_macros.svh
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/mmh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmh_pkg;

  // Length counter width
  localparam int COUNT_BITS = 31;

  // Hash constants
  localparam logic [31:0] MH_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MH_C2  = 32'h1b873593;
  localparam logic [31:0] MH_ADD = 32'he6546b64;
  localparam logic [31:0] MH_F1  = 32'h85ebca6b;
  localparam logic [31:0] MH_F2  = 32'hc2b2ae35;

  // Operand select of the shared multiplier
  typedef enum logic [2:0] {
    MUL_BLK,   // two-byte block times C1
    MUL_LOW,   // lone tail byte times C1
    MUL_K2,    // rotated k times C2
    MUL_AV1,   // first avalanche multiply
    MUL_AV2    // second avalanche multiply
  } mul_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     accept;      // input transfer this cycle
    logic     mul_en;      // load product register
    mul_sel_t mul_sel;
    logic     h_round;     // fold product into accumulator
    logic     fin_load;    // load finalizer word
    logic     fin_with_k;  // finalizer word includes tail k
    logic     out_load;    // load result, restart string
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pend_valid;  // a low byte waits for its partner
    logic out_busy;    // result register still held
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/murmur3_char_pair_hash.sv
// Steps: a first byte of a pair is only stored; the second byte passes
// twice through the shared multiplier, then through the h1 round.
// A closing item adds the finalizer (and a tail-byte mix with an odd length);
// the result is registered and the next string may start while it waits.
// Input: accepted only while idle; it stalls while the single shared multiplier mixes a pair or finalizes.
// Reset: synchronous, active low; seed clears to 0, no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module murmur3_char_pair_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,  // hash_seed
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] data_byte
  input  wire logic        in_tuser,     // [0] has_byte
  input  wire logic        in_tlast,     // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata     // [31:0] hash_value
);

  mmh_pkg::dp_cmd_t cmd;
  mmh_pkg::dp_sts_t sts;

  mmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

  mmh_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Result never overwrites one still held downstream
  `ASSERT_CLK(a_no_overwrite, cmd.out_load |-> !(out_tvalid && !out_tready), "result overwritten")
  // Second byte of a pair blocks input while the block is mixed
  `ASSERT_CLK(a_pair_stall, (in_tvalid && in_tready && in_tuser && sts.pend_valid) |=> !in_tready, "input not stalled during pair mix")
  // String state is cleared once a result is loaded
  `ASSERT_CLK(a_restart, cmd.out_load |=> (!sts.pend_valid && out_tvalid), "string state not cleared after result")

endmodule

`default_nettype wire

>>> hdl/mmh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mmh_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_tuser,   // has_byte
  input  wire logic             in_tlast,   // last_byte
  output mmh_pkg::dp_cmd_t      cmd,
  input  wire mmh_pkg::dp_sts_t sts
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_K2   = 4'd1;
  localparam logic [3:0] S_H    = 4'd2;
  localparam logic [3:0] S_FIN  = 4'd3;
  localparam logic [3:0] S_L2   = 4'd4;
  localparam logic [3:0] S_L3   = 4'd5;
  localparam logic [3:0] S_AV1  = 4'd6;
  localparam logic [3:0] S_AV2  = 4'd7;
  localparam logic [3:0] S_AV3  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       xfer;

  assign in_tready = (state_r == S_IDLE);
  assign xfer      = in_tvalid && in_tready;

  // Next state and command decode
  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    cmd            = '0;
    cmd.mul_sel    = mmh_pkg::MUL_BLK;
    unique case (state_r)
      S_IDLE: begin
        if (xfer) begin
          cmd.accept = 1'b1;
          last_nxt   = in_tlast;
          if (in_tuser && sts.pend_valid) begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mmh_pkg::MUL_BLK;
            state_nxt   = S_K2;
          end else if (in_tlast) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_K2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mmh_pkg::MUL_K2;
        state_nxt   = S_H;
      end
      S_H: begin
        cmd.h_round = 1'b1;
        state_nxt   = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (sts.pend_valid) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = mmh_pkg::MUL_LOW;
          state_nxt   = S_L2;
        end else begin
          cmd.fin_load = 1'b1;
          state_nxt    = S_AV1;
        end
      end
      S_L2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mmh_pkg::MUL_K2;
        state_nxt   = S_L3;
      end
      S_L3: begin
        cmd.fin_load   = 1'b1;
        cmd.fin_with_k = 1'b1;
        state_nxt      = S_AV1;
      end
      S_AV1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mmh_pkg::MUL_AV1;
        state_nxt   = S_AV2;
      end
      S_AV2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mmh_pkg::MUL_AV2;
        state_nxt   = S_AV3;
      end
      S_AV3: begin
        // wait for the result register to drain
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/mmh_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mmh_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [31:0]       cfg_wr_data,
  input  wire logic [7:0]        in_tdata,   // data_byte
  input  wire logic              in_tuser,   // has_byte
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output logic [31:0]            out_tdata,  // hash_value
  input  wire mmh_pkg::dp_cmd_t  cmd,
  output mmh_pkg::dp_sts_t       sts
);

  logic [31:0]                    seed_r;
  logic [31:0]                    accum_r, accum_nxt;
  logic [7:0]                     pend_low_r;
  logic                           pend_valid_r, pend_valid_nxt;
  logic [mmh_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic [31:0]                    prod_r;
  logic [31:0]                    fin_r;
  logic [31:0]                    out_data_r;
  logic                           out_valid_r;

  logic [31:0] mul_a, mul_b;
  logic [31:0] h_mix, h_rot;
  logic [31:0] len2;

  assign len2 = 32'({count_r, 1'b0});

  // Shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      mmh_pkg::MUL_BLK: begin
        mul_a = {8'h00, in_tdata, 8'h00, pend_low_r};
        mul_b = mmh_pkg::MH_C1;
      end
      mmh_pkg::MUL_LOW: begin
        mul_a = {24'h000000, pend_low_r};
        mul_b = mmh_pkg::MH_C1;
      end
      mmh_pkg::MUL_K2: begin
        mul_a = {prod_r[16:0], prod_r[31:17]};
        mul_b = mmh_pkg::MH_C2;
      end
      mmh_pkg::MUL_AV1: begin
        mul_a = fin_r ^ {16'h0000, fin_r[31:16]};
        mul_b = mmh_pkg::MH_F1;
      end
      mmh_pkg::MUL_AV2: begin
        mul_a = prod_r ^ {13'h0000, prod_r[31:13]};
        mul_b = mmh_pkg::MH_F2;
      end
      default: begin
        mul_a = prod_r;
        mul_b = mmh_pkg::MH_C1;
      end
    endcase
  end

  // h1 round: rotate 13, times 5 plus constant
  assign h_mix = accum_r ^ prod_r;
  assign h_rot = {h_mix[18:0], h_mix[31:19]};

  // Accumulator, pending byte and length update
  always_comb begin
    accum_nxt      = accum_r;
    pend_valid_nxt = pend_valid_r;
    count_nxt      = count_r;
    if (cmd.accept && in_tuser) begin
      count_nxt      = count_r + 1'b1;
      pend_valid_nxt = !pend_valid_r;
    end
    if (cmd.h_round) begin
      accum_nxt = h_rot + {h_rot[29:0], 2'b00} + mmh_pkg::MH_ADD;
    end
    if (cmd.out_load) begin
      accum_nxt      = seed_r;
      pend_valid_nxt = 1'b0;
      count_nxt      = '0;
    end
    // seed write reloads the accumulator between strings
    if (cfg_wr_en && (count_r == '0) && !pend_valid_r) begin
      accum_nxt = cfg_wr_data;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= '0;
      accum_r      <= '0;
      pend_valid_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      accum_r      <= accum_nxt;
      pend_valid_r <= pend_valid_nxt;
      count_r      <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && in_tuser && !pend_valid_r) begin
      pend_low_r <= in_tdata;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.fin_load) begin
      fin_r <= (cmd.fin_with_k ? (accum_r ^ prod_r) : accum_r) ^ len2;
    end
    if (cmd.out_load) begin
      out_data_r <= prod_r ^ {16'h0000, prod_r[31:16]};
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_busy   = out_valid_r && !out_tready;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_HALF      = 5;
  localparam int SETTLE_CYCLES = 16;     // covers the finalizer with an odd tail
  localparam int RUN_LIMIT_NS  = 3_000_000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = '0;         // hash_seed
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;         // [7:0] data_byte
  logic        in_tuser    = 1'b0;       // [0] has_byte
  logic        in_tlast    = 1'b0;       // last_byte
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;                // [31:0] hash_value

  murmur3_char_pair_hash dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // Hash model state
  logic [31:0]                    seed_model     = '0;
  logic [31:0]                    accum_model    = '0;
  logic [7:0]                     low_byte_held  = '0;
  logic                           low_held_valid = 1'b0;
  logic [mmh_pkg::COUNT_BITS-1:0] bytes_seen     = '0;
  logic [31:0]                    hash_queue[$];
  logic [31:0]                    expected_hash;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int error_count   = 0;
  int items_sent    = 0;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] scramble_k(input logic [31:0] k);
    logic [31:0] t;
    t = k * mmh_pkg::MH_C1;
    t = rotl32(t, 15);
    return t * mmh_pkg::MH_C2;
  endfunction

  function automatic logic [31:0] fold_round(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = rotl32(h ^ k, 13);
    return t * 32'd5 + mmh_pkg::MH_ADD;
  endfunction

  function automatic logic [31:0] finalize_hash(input logic [31:0] h, input logic [31:0] len2);
    logic [31:0] t;
    t = h ^ len2;
    t = t ^ (t >> 16);
    t = t * mmh_pkg::MH_F1;
    t = t ^ (t >> 13);
    t = t * mmh_pkg::MH_F2;
    return t ^ (t >> 16);
  endfunction

  // Advance the model by one accepted input transfer
  task automatic predict_transfer(input logic [7:0] b, input logic has, input logic last);
    logic [31:0] h;
    if (has) begin
      if (low_held_valid) begin
        accum_model    = fold_round(accum_model, scramble_k({8'h00, b, 8'h00, low_byte_held}));
        low_held_valid = 1'b0;
      end else begin
        low_byte_held  = b;
        low_held_valid = 1'b1;
      end
      bytes_seen = bytes_seen + 1'b1;
    end
    if (last) begin
      h = accum_model;
      if (low_held_valid)
        h = h ^ scramble_k({24'h0, low_byte_held});
      hash_queue.push_back(finalize_hash(h, {bytes_seen, 1'b0}));
      accum_model    = seed_model;
      low_byte_held  = '0;
      low_held_valid = 1'b0;
      bytes_seen     = '0;
    end
  endtask

  // Offer one item, with a random gap ahead of it
  task automatic send_item(input logic [7:0] b, input logic has, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= has;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_transfer(b, has, last);
    if (has || last)
      items_sent++;
  endtask

  // Stop offering, let every expected hash arrive, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (hash_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seed_model = v;
    if (bytes_seen == 0 && !low_held_valid)
      accum_model = v;
    @(posedge clk);
  endtask

  // One string of len random bytes, closed on the last byte or by an empty item
  task automatic send_string(input int len, input bit close_empty, input bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(3) == 0)
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, !close_empty && (i == len - 1));
    end
    if (close_empty || len == 0)
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Corner strings and seed handling
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);          // empty string, seed zero
    send_item(8'hff, 1'b0, 1'b0);          // idle item
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'ha5, 1'b1, 1'b0);          // odd tail closed by its byte
    send_item(8'h5a, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h12, 1'b1, 1'b0);          // even length, empty close
    send_item(8'h34, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);          // odd length, empty close
    send_item(8'hff, 1'b0, 1'b1);
    wait_idle();
    write_seed(32'hffff_ffff);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h7f, 1'b1, 1'b1);
    // seed write in the middle of a string applies to the next one
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hfe, 1'b1, 1'b0);
    send_item(8'h33, 1'b1, 1'b0);
    wait_idle();
    write_seed(32'h1234_5678);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input logic [31:0] seed, input int quota);
    int start;
    int kind;
    int len;
    wait_idle();
    write_seed(seed);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = items_sent;
    while (items_sent - start < quota) begin
      kind = $urandom_range(99);
      if (kind < 5)
        len = $urandom_range(48, 24);
      else
        len = $urandom_range(9, 0);
      send_string(len, $urandom_range(3) == 0, kind >= 85);
    end
  endtask

  // Random strings under three idling mixes and several seeds
  task automatic test_random_traffic();
    run_random_phase(9, 64, 32'h0000_0000, 134);
    run_random_phase(64, 9, 32'hffff_ffff, 133);
    run_random_phase(0, 0, $urandom, 133);
    wait_idle();
  endtask

  // Long receiver hold-off while short strings keep coming
  task automatic test_output_backpressure();
    write_seed($urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 400;
    for (int i = 0; i < 30; i++)
      send_string($urandom_range(2, 0), 1'b0, 1'b0);
    wait_idle();
  endtask

  // Result transfers: compare with the oldest expected hash, then drive ready
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if (hash_queue.size() == 0) begin
        $display("%0t: unexpected hash: expected none, actual %h", $time, out_tdata);
        error_count++;
      end else begin
        expected_hash = hash_queue.pop_front();
        if (out_tdata !== expected_hash) begin
          $display("%0t: hash_value mismatch: expected %h, actual %h",
                   $time, expected_hash, out_tdata);
          error_count++;
        end
      end
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic();
    test_output_backpressure();
    wait_idle();
    if (error_count == 0 && hash_queue.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/mmh_pkg.sv
hdl/mmh_ctrl.sv
hdl/mmh_datapath.sv
hdl/murmur3_char_pair_hash.sv
sim/testbench.sv
